// ===== rtl/core/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared widths, fixed-point constants and helper functions for the HSL to
// RGB converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgb_pkg;

    // Fixed-point format: FRAC_BITS fraction bits, one integer bit
    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = FRAC_BITS;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int WIDE_W    = FX_W + 3;
    localparam int NCH       = 3;

    // Products: lightness * saturation and ramp difference * slope
    localparam int LS_PROD_W   = FX_W + FX_W;
    localparam int RAMP_PROD_W = FX_W + HUE_W;

    localparam logic [FX_W-1:0] ONE        = FX_W'(1) << FRAC_BITS;
    localparam logic [FX_W-1:0] HALF       = ONE / 2;
    localparam logic [FX_W-1:0] THIRD      = ONE / 3;
    localparam logic [FX_W-1:0] SIXTH      = ONE / 6;
    localparam logic [FX_W-1:0] TWO_THIRDS = FX_W'((2 * (1 << FRAC_BITS)) / 3);

    // Channel slots
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Piece of the hue ramp that a hue offset falls in
    typedef enum logic [1:0] {
        RGN_RISE,
        RGN_HIGH,
        RGN_FALL,
        RGN_LOW
    } region_t;

    function automatic region_t ramp_region(input logic [HUE_W-1:0] t);
        logic [FX_W-1:0] tx;
        tx = {1'b0, t};
        if (tx < SIXTH) begin
            return RGN_RISE;
        end else if (tx < HALF) begin
            return RGN_HIGH;
        end else if (tx < TWO_THIRDS) begin
            return RGN_FALL;
        end
        return RGN_LOW;
    endfunction

    // Slope factor 6*t on the rising edge, 6*(2/3 - t) on the falling edge.
    // Both stay below ONE inside their region; elsewhere the value is unused.
    function automatic logic [HUE_W-1:0] ramp_slope(input logic [HUE_W-1:0] t);
        logic [FX_W-1:0] tx;
        logic [FX_W-1:0] reach;
        logic [FX_W+2:0] six;
        tx = {1'b0, t};
        if (tx < SIXTH) begin
            reach = tx;
        end else if ((tx >= HALF) && (tx < TWO_THIRDS)) begin
            reach = TWO_THIRDS - tx;
        end else begin
            reach = '0;
        end
        six = (FX_W+3)'(reach) * (FX_W+3)'(6);
        return six[HUE_W-1:0];
    endfunction

    // Clamp a signed intermediate to 0..ONE
    function automatic logic [FX_W-1:0] clamp_unit(input logic signed [WIDE_W-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > $signed({3'b000, ONE})) begin
            return ONE;
        end
        return v[FX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Fixed-point HSL to RGB, fully pipelined, one word per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one word (hue, saturation, lightness) every clock cycle while not
// stalled and returns one word (red, green, blue) per input, in order. The
// word passes five register stages: input saturation and hue offsets, the
// lightness*saturation multiply, the p/q computation, the three per-channel
// ramp multiplies, and the output register. The first stage loads at the
// accepting edge, and m_valid rises when the word reaches the output register.
// Each stage holds its word while the next stage is full and stalled, so
// backpressure on m_ready stalls only as far back as needed and a bubble is
// filled by the next input. Saturation and lightness above 1.0 are clamped
// to 1.0; all outputs lie in 0..65536 where 65536 means 1.0.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [HUE_W-1:0]  s_hue,
    input  wire logic [FX_W-1:0]   s_saturation,
    input  wire logic [FX_W-1:0]   s_lightness,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [FX_W-1:0]        m_red,
    output logic [FX_W-1:0]        m_green,
    output logic [FX_W-1:0]        m_blue
);

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------
    logic [5:1] vld_reg;
    logic [5:1] vld_next;
    logic [5:1] adv;

    always_comb begin
        adv[5] = !vld_reg[5] || m_ready;
        adv[4] = !vld_reg[4] || adv[5];
        adv[3] = !vld_reg[3] || adv[4];
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
    end

    always_comb begin
        vld_next = vld_reg;
        if (adv[1]) vld_next[1] = s_valid;
        if (adv[2]) vld_next[2] = vld_reg[1];
        if (adv[3]) vld_next[3] = vld_reg[2];
        if (adv[4]) vld_next[4] = vld_reg[3];
        if (adv[5]) vld_next[5] = vld_reg[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[1];
    assign m_valid = vld_reg[5];

    // ------------------------------------------------------------------
    // Stage 1: clamp inputs, hue offsets, ramp region and slope per channel
    // ------------------------------------------------------------------
    logic [FX_W-1:0]  s1_sat_reg, s1_sat_next;
    logic [FX_W-1:0]  s1_lig_reg, s1_lig_next;
    region_t          s1_rgn_reg   [NCH];
    region_t          s1_rgn_next  [NCH];
    logic [HUE_W-1:0] s1_slope_reg [NCH];
    logic [HUE_W-1:0] s1_slope_next[NCH];
    logic [HUE_W-1:0] hue_off      [NCH];

    always_comb begin
        s1_sat_next = (s_saturation > ONE) ? ONE : s_saturation;
        s1_lig_next = (s_lightness > ONE) ? ONE : s_lightness;
        // offsets wrap modulo one turn
        hue_off[CH_RED]   = s_hue + THIRD[HUE_W-1:0];
        hue_off[CH_GREEN] = s_hue;
        hue_off[CH_BLUE]  = s_hue - THIRD[HUE_W-1:0];
        for (int c = 0; c < NCH; c++) begin
            s1_rgn_next[c]   = ramp_region(hue_off[c]);
            s1_slope_next[c] = ramp_slope(hue_off[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_sat_reg   <= s1_sat_next;
            s1_lig_reg   <= s1_lig_next;
            s1_rgn_reg   <= s1_rgn_next;
            s1_slope_reg <= s1_slope_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: lightness * saturation
    // ------------------------------------------------------------------
    logic [LS_PROD_W-1:0] s2_ls_reg, s2_ls_next;
    logic [FX_W-1:0]      s2_sat_reg;
    logic [FX_W-1:0]      s2_lig_reg;
    region_t              s2_rgn_reg   [NCH];
    logic [HUE_W-1:0]     s2_slope_reg [NCH];

    assign s2_ls_next = LS_PROD_W'(s1_lig_reg) * LS_PROD_W'(s1_sat_reg);

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s2_ls_reg    <= s2_ls_next;
            s2_sat_reg   <= s1_sat_reg;
            s2_lig_reg   <= s1_lig_reg;
            s2_rgn_reg   <= s1_rgn_reg;
            s2_slope_reg <= s1_slope_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: q and p, clamped and ordered, ramp span
    // ------------------------------------------------------------------
    logic [FX_W-1:0]          ls_fx;
    logic signed [WIDE_W-1:0] q_raw;
    logic signed [WIDE_W-1:0] p_raw;
    logic [FX_W-1:0]          q_c;
    logic [FX_W-1:0]          p_c;
    logic [FX_W-1:0]          s3_lo_reg, s3_lo_next;
    logic [FX_W-1:0]          s3_hi_reg, s3_hi_next;
    logic [FX_W-1:0]          s3_span_reg, s3_span_next;
    region_t                  s3_rgn_reg   [NCH];
    logic [HUE_W-1:0]         s3_slope_reg [NCH];

    always_comb begin
        // product never exceeds ONE*ONE, so its top bit is always clear
        ls_fx = s2_ls_reg[FRAC_BITS +: FX_W];
        if (s2_lig_reg < HALF) begin
            q_raw = $signed(WIDE_W'(s2_lig_reg)) + $signed(WIDE_W'(ls_fx));
        end else begin
            q_raw = $signed(WIDE_W'(s2_lig_reg)) + $signed(WIDE_W'(s2_sat_reg))
                  - $signed(WIDE_W'(ls_fx));
        end
        q_c   = clamp_unit(q_raw);
        p_raw = $signed(WIDE_W'({s2_lig_reg, 1'b0})) - $signed(WIDE_W'(q_c));
        p_c   = clamp_unit(p_raw);
        // flat ramp at p if q ends up below p
        s3_lo_next   = p_c;
        s3_hi_next   = (q_c < p_c) ? p_c : q_c;
        s3_span_next = s3_hi_next - s3_lo_next;
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s3_lo_reg    <= s3_lo_next;
            s3_hi_reg    <= s3_hi_next;
            s3_span_reg  <= s3_span_next;
            s3_rgn_reg   <= s2_rgn_reg;
            s3_slope_reg <= s2_slope_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: per-channel span * slope, drop the low FRAC_BITS fraction bits, keep the upper part
    // ------------------------------------------------------------------
    logic [RAMP_PROD_W-1:0] ramp_prod   [NCH];
    logic [FX_W-1:0]        s4_step_reg [NCH];
    logic [FX_W-1:0]        s4_step_next[NCH];
    logic [FX_W-1:0]        s4_lo_reg;
    logic [FX_W-1:0]        s4_hi_reg;
    region_t                s4_rgn_reg  [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            ramp_prod[c]    = RAMP_PROD_W'(s3_span_reg) * RAMP_PROD_W'(s3_slope_reg[c]);
            s4_step_next[c] = ramp_prod[c][FRAC_BITS +: FX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s4_step_reg <= s4_step_next;
            s4_lo_reg   <= s3_lo_reg;
            s4_hi_reg   <= s3_hi_reg;
            s4_rgn_reg  <= s3_rgn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: pick the ramp piece, clamp, output register
    // ------------------------------------------------------------------
    logic [FX_W:0]   ramp_sum  [NCH];
    logic [FX_W-1:0] s5_ch_reg [NCH];
    logic [FX_W-1:0] s5_ch_next[NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            ramp_sum[c] = {1'b0, s4_lo_reg} + {1'b0, s4_step_reg[c]};
            unique case (s4_rgn_reg[c])
                RGN_RISE, RGN_FALL: begin
                    s5_ch_next[c] = (ramp_sum[c] > {1'b0, ONE}) ? ONE
                                                                : ramp_sum[c][FX_W-1:0];
                end
                RGN_HIGH: s5_ch_next[c] = s4_hi_reg;
                RGN_LOW:  s5_ch_next[c] = s4_lo_reg;
                default:  s5_ch_next[c] = s4_lo_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s5_ch_reg <= s5_ch_next;
        end
    end

    assign m_red   = s5_ch_reg[CH_RED];
    assign m_green = s5_ch_reg[CH_GREEN];
    assign m_blue  = s5_ch_reg[CH_BLUE];

`ifndef SYNTHESIS
    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !vld_reg[3])
        else $error("pipeline not empty after reset");

    // a free output stage means the whole pipe can take a word
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output stage is free");

    // ramp bounds are ordered and span matches them
    a_ramp_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (s3_hi_reg >= s3_lo_reg)
                       && (s3_span_reg == s3_hi_reg - s3_lo_reg)
                       && (s3_hi_reg <= ONE))
        else $error("ramp bounds out of order");

    // delivered channels stay within one
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red <= ONE) && (m_green <= ONE) && (m_blue <= ONE))
        else $error("output channel above one");

    // a stalled output word does not let a new word into the output stage
    a_stall_holds_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(s5_ch_reg[CH_GREEN]))
        else $error("output stage overwritten during stall");
`endif

endmodule

`default_nettype wire
